FILE: rtl/sbad_pkg.sv
// ---------------------------------------------------------------------------
// sbad_pkg: shared definitions for the binary to decimal text converter
// Character codes, default width, digit count and the handoff word between
// the bit-serial converter and the character emitter.
// ---------------------------------------------------------------------------
package sbad_pkg;

    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [7:0] ZERO_CODE  = 8'd48;
    localparam logic [7:0] MINUS_CODE = 8'd45;
    localparam logic [7:0] NUL_CODE   = 8'd0;
    localparam logic [7:0] NINE_CODE  = 8'd57;

    // decimal digits of 2^(w-1), the largest magnitude; 77/256 sits just under log10(2)
    function automatic int digit_count(input int w);
        return ((w - 1) * 77) / 256 + 1;
    endfunction

    // handoff from converter to emitter
    typedef struct packed {
        logic valid;
        logic neg;
    } t_conv;

endpackage

FILE: rtl/sbad_dabble.sv
// ---------------------------------------------------------------------------
// sbad_dabble: bit-serial binary to bcd converter
// Takes the magnitude of the signed word and shifts it into a bcd register
// one bit per cycle, adding three to each digit of five or more first.
// ---------------------------------------------------------------------------
module sbad_dabble
    import sbad_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int NUM_DIGITS  = digit_count(DEF_VALUE_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_value_valid,
    output logic                          o_value_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output t_conv                         o_conv,
    input  logic                          i_conv_ready,
    output logic [4*NUM_DIGITS-1:0]       o_bcd
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int BW = 4 * NUM_DIGITS;

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic                   r_neg,  n_neg;
    logic [VALUE_WIDTH-1:0] r_mag,  n_mag;
    logic [BW-1:0]          r_bcd,  n_bcd;
    logic [CW-1:0]          r_cnt,  n_cnt;

    logic [VALUE_WIDTH-1:0] v_raw;
    logic [BW-1:0]          v_adj;

    assign o_value_ready = !r_busy && !r_done;
    assign o_conv.valid  = r_done;
    assign o_conv.neg    = r_neg;
    assign o_bcd         = r_bcd;
    assign v_raw         = $unsigned(i_value);

    // add-three correction, each digit on its own
    always_comb begin
        logic [3:0] v_dig;
        v_dig = 4'd0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            v_dig = r_bcd[4*d +: 4];
            v_adj[4*d +: 4] = (v_dig >= 4'd5) ? v_dig + 4'd3 : v_dig;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        if (i_value_valid && o_value_ready) begin
            n_neg  = v_raw[VALUE_WIDTH-1];
            // most negative value wraps to 2^(w-1), which is its true magnitude
            n_mag  = v_raw[VALUE_WIDTH-1] ? (~v_raw + VALUE_WIDTH'(1)) : v_raw;
            n_bcd  = '0;
            n_cnt  = CW'(VALUE_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {v_adj[BW-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag = r_mag << 1;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (r_done && i_conv_ready) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("converter busy and done together");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("converter busy with empty bit count");

    a_done_after_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == CW'(1) |=> r_done)
        else $error("converter did not finish after last bit");

endmodule

FILE: rtl/sbad_emit.sv
// ---------------------------------------------------------------------------
// sbad_emit: character emitter
// Strips leading zero digits, then sends sign, digits and terminator one
// word per cycle while the receiver is ready, through a registered output stage.
// ---------------------------------------------------------------------------
module sbad_emit
    import sbad_pkg::*;
#(
    parameter int NUM_DIGITS = digit_count(DEF_VALUE_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_conv                   i_conv,
    output logic                    o_conv_ready,
    input  logic [4*NUM_DIGITS-1:0] i_bcd,
    output logic                    o_char_valid,
    input  logic                    i_char_ready,
    output logic [7:0]              o_char_code,
    output logic                    o_last
);

    localparam int BW = 4 * NUM_DIGITS;
    localparam int LW = $clog2(NUM_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SKIP  = 4'b0010,
        S_DIGIT = 4'b0100,
        S_TERM  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [BW-1:0] r_shift, n_shift;
    logic [LW-1:0] r_left,  n_left;
    logic          r_neg_pend, n_neg_pend;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_code, n_code;
    logic          r_last, n_last;

    logic          v_free;
    logic [3:0]    v_top;

    assign v_free       = !r_ovalid || i_char_ready;
    assign v_top        = r_shift[BW-1 -: 4];
    assign o_conv_ready = (r_state == S_IDLE);
    assign o_char_valid = r_ovalid;
    assign o_char_code  = r_code;
    assign o_last       = r_last;

    always_comb begin
        n_state    = r_state;
        n_shift    = r_shift;
        n_left     = r_left;
        n_neg_pend = r_neg_pend;
        n_ovalid   = v_free ? 1'b0 : r_ovalid;
        n_code     = r_code;
        n_last     = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_conv.valid) begin
                    n_shift    = i_bcd;
                    n_left     = LW'(NUM_DIGITS);
                    n_neg_pend = i_conv.neg;
                    n_state    = S_SKIP;
                end
            end
            S_SKIP: begin
                // keep at least one digit so zero prints as "0"
                if (v_top == 4'd0 && r_left != LW'(1)) begin
                    n_shift = r_shift << 4;
                    n_left  = r_left - LW'(1);
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (v_free) begin
                    n_ovalid = 1'b1;
                    n_last   = 1'b0;
                    if (r_neg_pend) begin
                        n_code     = MINUS_CODE;
                        n_neg_pend = 1'b0;
                    end else begin
                        n_code  = ZERO_CODE + {4'd0, v_top};
                        n_shift = r_shift << 4;
                        n_left  = r_left - LW'(1);
                        if (r_left == LW'(1)) begin
                            n_state = S_TERM;
                        end
                    end
                end
            end
            S_TERM: begin
                if (v_free) begin
                    n_ovalid = 1'b1;
                    n_code   = NUL_CODE;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_left     <= '0;
            r_neg_pend <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_left     <= n_left;
            r_neg_pend <= n_neg_pend;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_code  <= n_code;
        r_last  <= n_last;
    end

    a_digit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT || r_state == S_SKIP) |-> r_left != '0)
        else $error("emitter out of digits before terminator");

    a_idle_no_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_neg_pend)
        else $error("sign still pending after terminator");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid && !o_last |->
            (o_char_code == MINUS_CODE ||
             (o_char_code >= ZERO_CODE && o_char_code <= NINE_CODE)))
        else $error("emitted character is neither sign nor digit");

    // the next number may already be loading while the terminator is held
    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid && o_last |-> o_char_code == NUL_CODE)
        else $error("terminator word is not nul");

endmodule

FILE: rtl/signed_binary_to_ascii_decimal.sv
// ---------------------------------------------------------------------------
// signed_binary_to_ascii_decimal: signed integer to ascii decimal text
// Converts one signed word per item into its decimal text, one character
// word at a time, most significant first.
// ---------------------------------------------------------------------------
// Usage:
//   input channel  i_value_valid / o_value_ready, payload i_value (signed)
//   output channel o_char_valid / i_char_ready, payload o_char_code, o_last
//   each number gives an optional '-', its digits with no leading zeros
//   (zero gives "0"), then a nul word with o_last high
// Flow:
//   the converter shifts one bit per cycle; the emitter then drops up to
//   NUM_DIGITS-1 leading zeros, one per cycle, and sends one character per
//   cycle while the receiver is ready
//   the next number converts while the previous one is still being sent,
//   so at 32 bits the bit-serial shift sets the rate at which numbers pass
// Reset:
//   synchronous, active low; the output stage empties and both units go idle
// Stall:
//   a held character keeps its register; the emitter and then the converter
//   wait, and o_value_ready drops until the converter is free again
// ---------------------------------------------------------------------------
module signed_binary_to_ascii_decimal
    import sbad_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_value_valid,
    output logic                          o_value_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_char_valid,
    input  logic                          i_char_ready,
    output logic [7:0]                    o_char_code,
    output logic                          o_last
);

    localparam int NUM_DIGITS = digit_count(VALUE_WIDTH);

    t_conv                   w_conv;
    logic                    w_conv_ready;
    logic [4*NUM_DIGITS-1:0] w_bcd;

    sbad_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_value_valid),
        .o_value_ready (o_value_ready),
        .i_value       (i_value),
        .o_conv        (w_conv),
        .i_conv_ready  (w_conv_ready),
        .o_bcd         (w_bcd)
    );

    sbad_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_conv       (w_conv),
        .o_conv_ready (w_conv_ready),
        .i_bcd        (w_bcd),
        .o_char_valid (o_char_valid),
        .i_char_ready (i_char_ready),
        .o_char_code  (o_char_code),
        .o_last       (o_last)
    );

endmodule

FILE: test/signed_binary_to_ascii_decimal_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// signed_binary_to_ascii_decimal_test: self-checking bench for the converter
// Sends signed values, predicts each character word of the decimal text and
// compares it in order with the output stream. Covers boundary values,
// random values of every digit count, sender gaps, receiver stalls, and a
// long output hold that fills the block and stalls its input.
// ---------------------------------------------------------------------------
module signed_binary_to_ascii_decimal_test;
    import sbad_pkg::*;

    localparam int VALUE_WIDTH  = DEF_VALUE_WIDTH;
    localparam int DIGIT_BASE   = 10;
    localparam int SETTLE_LEN   = VALUE_WIDTH + 16;
    localparam int STUCK_LIMIT  = 4000;
    localparam int HOLD_LEN     = 400;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_value_valid;
    logic                          o_value_ready;
    logic signed [VALUE_WIDTH-1:0] i_value;
    logic                          o_char_valid;
    logic                          i_char_ready;
    logic [7:0]                    o_char_code;
    logic                          o_last;

    t_text_char text_q[$];
    int         errors;
    int         tx_idle_pct;
    int         rx_stall_pct;
    int         rx_hold_req;
    int         rx_hold_taken;
    int         rx_hold_left;
    int         stuck_cycles;

    signed_binary_to_ascii_decimal #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_value_valid),
        .o_value_ready (o_value_ready),
        .i_value       (i_value),
        .o_char_valid  (o_char_valid),
        .i_char_ready  (i_char_ready),
        .o_char_code   (o_char_code),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // expected text of one value: optional minus, digits msd first, nul
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [7:0]  digits[$];
        logic        neg;
        mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        neg  = raw[VALUE_WIDTH-1];
        mag  = 64'(raw);
        if (neg) begin
            mag = (~mag + 64'd1) & mask;
        end
        do begin
            digits.push_front(ZERO_CODE + 8'(mag % DIGIT_BASE));
            mag = mag / DIGIT_BASE;
        end while (mag != 0);
        if (neg) begin
            text_q.push_back('{code: MINUS_CODE, last: 1'b0});
        end
        foreach (digits[i]) begin
            text_q.push_back('{code: digits[i], last: 1'b0});
        end
        text_q.push_back('{code: NUL_CODE, last: 1'b1});
    endfunction

    // inputs are predicted before outputs are checked in the same edge
    always @(posedge i_clk) begin : check_proc
        t_text_char want;
        if (i_rst_n) begin
            if (i_value_valid && o_value_ready) begin
                predict_text(i_value);
            end
            if (o_char_valid && i_char_ready) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual code %0d last %0b",
                             $time, o_char_code, o_last);
                    errors++;
                end else begin
                    want = text_q.pop_front();
                    if (o_char_code !== want.code) begin
                        $display("%0t: char_code mismatch: expected %0d, actual %0d",
                                 $time, want.code, o_char_code);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_taken != rx_hold_req) begin
            rx_hold_taken = rx_hold_req;
            rx_hold_left  = HOLD_LEN;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_char_ready <= 1'b0;
        end else begin
            i_char_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_value_valid && o_value_ready) || (o_char_valid && i_char_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d words still expected",
                     $time, STUCK_LIMIT, text_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // called just after a rising edge; returns at the edge that takes the word
    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_value_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_value_valid <= 1'b1;
        i_value       <= v;
        do @(posedge i_clk); while (!o_value_ready);
    endtask

    task automatic wait_drained();
        i_value_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    // random value with a random digit count and sign, or raw random bits
    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        logic   neg;
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        n   = $urandom_range(10, 1);
        neg = 1'($urandom_range(1));
        lo  = 1;
        repeat (n - 1) lo *= DIGIT_BASE;
        hi = lo * DIGIT_BASE - 1;
        if (hi > 64'sd2147483648) begin
            hi = 64'sd2147483648;
        end
        if (!neg && hi == 64'sd2147483648) begin
            hi = 64'sd2147483647;
        end
        mag = lo + longint'($urandom_range(32'(hi - lo)));
        return VALUE_WIDTH'(neg ? -mag : mag);
    endfunction

    task automatic test_directed_values();
        logic signed [VALUE_WIDTH-1:0] vals[$];
        vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, 32'sh7fffffff, 32'sh80000000, 32'sh80000001,
                 32'sd1000000000, 32'sd999999999, -32'sd999999999,
                 32'sd1234567890, -32'sd1000000000, 32'sh55555555,
                 32'shaaaaaaaa, 32'sd7, -32'sd7, 32'sd4294967};
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (vals[i]) begin
            send_value(vals[i]);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_value(random_value());
        wait_drained();
    endtask

    // output held off while values keep coming, so the block fills and stalls
    task automatic test_output_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req++;
        repeat (24) send_value(random_value());
        wait_drained();
    endtask

    initial begin
        errors        = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rx_hold_req   = 0;
        rx_hold_taken = 0;
        rx_hold_left  = 0;
        stuck_cycles  = 0;
        i_rst_n       <= 1'b0;
        i_value_valid <= 1'b0;
        i_value       <= '0;
        i_char_ready  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_values();
        test_random_traffic(110, 0, 0);
        test_random_traffic(110, 75, 0);
        test_random_traffic(110, 0, 75);
        test_random_traffic(110, 32, 32);
        test_output_hold();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: signed_binary_to_ascii_decimal.f
rtl/sbad_pkg.sv
rtl/sbad_dabble.sv
rtl/sbad_emit.sv
rtl/signed_binary_to_ascii_decimal.sv
test/signed_binary_to_ascii_decimal_test.sv
